// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the buddy page allocator: field widths,
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int ORD_W     = 4;   // request order field
    localparam int PAGE_IN_W = 16;  // page fields on the ports
    localparam int CNT_W     = 17;  // free page counter
    localparam int B_W       = 5;   // working order, may step one past the top
    localparam int POOL_W    = 5;   // pool_order register

    localparam logic [POOL_W-1:0] POOL_ORDER_RST = 5'd11;
    localparam logic [CNT_W-1:0]  CNT_MAX        = '1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_MEM   = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [3:0] {
        S_INIT, S_FILL, S_IDLE, S_DISPATCH,
        S_A_SCAN, S_A_LATCH, S_A_SPLIT,
        S_F_RD, S_F_CMP, S_F_CRD, S_F_CWR,
        S_DONE
    } bpa_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_INIT, OP_FILL, OP_ACCEPT,
        OP_SET_INVALID, OP_SET_NOMEM,
        OP_SCAN_NEXT, OP_POP, OP_LATCH, OP_SPLIT, OP_ALLOC_FIN,
        OP_RD_IDX, OP_IDX_INC, OP_RD_IDX1, OP_WR_IDX, OP_MERGE, OP_PUSH_FREE,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } bpa_cmd_t;

    typedef struct packed {
        logic ord_bad;    // requested order above the top order
        logic is_free;    // current request is a free
        logic cnt_zero;   // list at working order is empty (or order past top)
        logic b_gt_max;   // working order past the top order
        logic b_gt_ord;   // working order above requested order
        logic b_lt_max;   // working order can still merge
        logic idx_end;    // scan index reached list count
        logic hit;        // read entry equals the buddy
        logic comp_last;  // compaction reached last entry
        logic fill_last;  // last initial chunk being written
    } bpa_stat_t;

endpackage

// ===== src/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller for the buddy page allocator: sequences pool fill, the alloc
// scan/pop/split walk and the free buddy search/compaction/merge walk, and
// owns the input and result handshakes.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output bpa_cmd_t  cmd,
    input  bpa_stat_t stat
);

    bpa_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    // state and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_INIT: begin
                cmd.op     = OP_INIT;
                state_next = S_FILL;
            end
            S_FILL: begin
                cmd.op = OP_FILL;
                if (stat.fill_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && !cfg_wr_en) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (stat.ord_bad) begin
                    cmd.op     = OP_SET_INVALID;
                    state_next = S_DONE;
                end else if (stat.is_free) begin
                    state_next = S_F_RD;
                end else begin
                    state_next = S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                if (stat.b_gt_max) begin
                    cmd.op     = OP_SET_NOMEM;
                    state_next = S_DONE;
                end else if (stat.cnt_zero) begin
                    cmd.op = OP_SCAN_NEXT;
                end else begin
                    cmd.op     = OP_POP;
                    state_next = S_A_LATCH;
                end
            end
            S_A_LATCH: begin
                cmd.op     = OP_LATCH;
                state_next = S_A_SPLIT;
            end
            S_A_SPLIT: begin
                if (stat.b_gt_ord) begin
                    cmd.op = OP_SPLIT;
                end else begin
                    cmd.op     = OP_ALLOC_FIN;
                    state_next = S_DONE;
                end
            end
            S_F_RD: begin
                if (!stat.b_lt_max || stat.idx_end) begin
                    cmd.op     = OP_PUSH_FREE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_RD_IDX;
                    state_next = S_F_CMP;
                end
            end
            S_F_CMP: begin
                if (stat.hit) begin
                    state_next = S_F_CRD;
                end else begin
                    cmd.op     = OP_IDX_INC;
                    state_next = S_F_RD;
                end
            end
            S_F_CRD: begin
                if (stat.comp_last) begin
                    cmd.op     = OP_MERGE;
                    state_next = S_F_RD;
                end else begin
                    cmd.op     = OP_RD_IDX1;
                    state_next = S_F_CWR;
                end
            end
            S_F_CWR: begin
                cmd.op     = OP_WR_IDX;
                state_next = S_F_CRD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op     = OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
        // a register write re-initializes the pool
        if (cfg_wr_en) begin
            state_next = S_INIT;
        end
    end

    // result beat held until taken
    always_comb begin
        if (cmd.op == OP_OUT_LOAD) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !cfg_wr_en;
    assign m_valid = m_valid_reg;

endmodule

// ===== src/bpa_dp.sv =====
// ----------------------------------------------------------------------------
// bpa_dp
// Datapath for the buddy page allocator: per-order ring heads and counts,
// the free list memory, the free page counter and the result registers.
// ----------------------------------------------------------------------------
module bpa_dp import bpa_pkg::*; #(
    parameter int TOP_ORDER  = 11,
    parameter int LIST_DEPTH = 32,
    parameter int PAGE_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [POOL_W-1:0]    cfg_wr_data,
    input  logic                 s_req_type,
    input  logic [ORD_W-1:0]     s_order,
    input  logic [PAGE_IN_W-1:0] s_page_start,
    input  bpa_cmd_t             cmd,
    output bpa_stat_t            stat,
    output logic [1:0]           m_status,
    output logic [PAGE_IN_W-1:0] m_alloc_page,
    output logic [CNT_W-1:0]     m_free_page_count
);

    localparam int NORD  = TOP_ORDER + 1;
    localparam int SW    = $clog2(LIST_DEPTH);
    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int OIW   = $clog2(NORD);
    localparam int DEPTH = NORD * LIST_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CW:0] LD_S = (CW+1)'(LIST_DEPTH);
    localparam logic [CW-1:0] LD_C = CW'(LIST_DEPTH);

    // ring index: head plus offset, wrapped once
    function automatic logic [SW-1:0] wrap(input logic [SW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(k);
        if (s >= LD_S) begin
            s = s - LD_S;
        end
        return s[SW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [B_W-1:0] o, input logic [SW-1:0] sl);
        logic [31:0] a;
        a = 32'(o) * LIST_DEPTH + 32'(sl);
        return a[AW-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] add_sat(input logic [CNT_W-1:0] t,
                                                 input logic [CNT_W-1:0] a);
        logic [CNT_W:0] s;
        s = {1'b0, t} + {1'b0, a};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sub_sat(input logic [CNT_W-1:0] t,
                                                 input logic [CNT_W-1:0] a);
        return (a > t) ? '0 : t - a;
    endfunction

    // control state
    logic [POOL_W-1:0]    pool_reg;
    logic [B_W-1:0]       b_reg;
    logic [CW-1:0]        idx_reg;
    logic [SW-1:0]        head_reg [NORD];
    logic [CW-1:0]        cnt_reg  [NORD];
    logic [CNT_W-1:0]     total_reg;

    // payload state
    req_t                 req_reg;
    logic [ORD_W-1:0]     ord_reg;
    logic [PAGE_BITS-1:0] c_reg;
    logic [PAGE_BITS-1:0] res_reg;
    status_t              st_reg;
    status_t              m_status_reg;
    logic [PAGE_IN_W-1:0] m_alloc_reg;
    logic [CNT_W-1:0]     m_count_reg;

    // memory port
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [PAGE_BITS-1:0] ram_wdata, ram_rdata;

    // derived values
    logic [OIW-1:0]       bi, nbi;
    logic [B_W-1:0]       nb;
    logic                 b_le_max;
    logic [CW-1:0]        cnt_cur, cnt_nb;
    logic [SW-1:0]        head_cur;
    logic [PAGE_BITS-1:0] bit_b, bit_nb, buddy, page_in, ord_mask;
    logic [31:0]          pg32, res32, eff, e, n32, init32, over32;
    logic [CW-1:0]        n_init;
    logic [CNT_W-1:0]     init_total, ord_pages, over_pages;
    logic                 full;

    assign bi       = b_reg[OIW-1:0];
    assign nb       = b_reg - B_W'(1);
    assign nbi      = nb[OIW-1:0];
    assign b_le_max = 32'(b_reg) <= TOP_ORDER;
    assign cnt_cur  = b_le_max ? cnt_reg[bi] : '0;
    assign head_cur = b_le_max ? head_reg[bi] : '0;
    assign cnt_nb   = cnt_reg[nbi];
    assign bit_b    = PAGE_BITS'(32'd1 << b_reg);
    assign bit_nb   = PAGE_BITS'(32'd1 << nb);
    assign buddy    = c_reg ^ bit_b;
    assign full     = cnt_cur == LD_C;
    assign pg32     = 32'(s_page_start);
    assign page_in  = pg32[PAGE_BITS-1:0];
    assign ord_mask = PAGE_BITS'(~((32'd1 << s_order) - 32'd1));
    assign ord_pages  = CNT_W'(32'd1 << ord_reg);
    assign over32     = (32'd1 << b_reg) - (32'd1 << ord_reg);
    assign over_pages = over32[CNT_W-1:0];
    assign res32      = 32'(res_reg);

    // initial chunk count from the clamped pool order
    always_comb begin
        eff = 32'(pool_reg);
        if (eff < TOP_ORDER) begin
            eff = TOP_ORDER;
        end
        if (eff > PAGE_BITS) begin
            eff = PAGE_BITS;
        end
        e = eff - TOP_ORDER;
        if (e >= CW) begin
            n32 = LIST_DEPTH;
        end else if ((32'd1 << e) > LIST_DEPTH) begin
            n32 = LIST_DEPTH;
        end else begin
            n32 = 32'd1 << e;
        end
        init32 = n32 << TOP_ORDER;
        init_total = (init32 > 32'(CNT_MAX)) ? CNT_MAX : init32[CNT_W-1:0];
    end
    assign n_init = n32[CW-1:0];

    // status to the controller
    always_comb begin
        stat.ord_bad   = 32'(ord_reg) > TOP_ORDER;
        stat.is_free   = req_reg == REQ_FREE;
        stat.cnt_zero  = cnt_cur == '0;
        stat.b_gt_max  = !b_le_max;
        stat.b_gt_ord  = b_reg > B_W'(ord_reg);
        stat.b_lt_max  = 32'(b_reg) < TOP_ORDER;
        stat.idx_end   = idx_reg == cnt_cur;
        stat.hit       = ram_rdata == buddy;
        stat.comp_last = ((CW+1)'(idx_reg) + (CW+1)'(1)) == (CW+1)'(cnt_cur);
        stat.fill_last = idx_reg == (n_init - CW'(1));
    end

    // memory addressing
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_of(b_reg, wrap(head_cur, idx_reg));
        ram_wdata = ram_rdata;
        ram_raddr = addr_of(b_reg, wrap(head_cur, idx_reg));
        unique case (cmd.op)
            OP_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(B_W'(TOP_ORDER), idx_reg[SW-1:0]);
                ram_wdata = PAGE_BITS'(32'(idx_reg) << TOP_ORDER);
            end
            OP_POP: ram_raddr = addr_of(b_reg, head_cur);
            OP_RD_IDX1: ram_raddr = addr_of(b_reg, wrap(head_cur, idx_reg + CW'(1)));
            OP_SPLIT: begin
                ram_we    = 1'b1;
                ram_waddr = addr_of(nb, wrap(head_reg[nbi], cnt_nb));
                ram_wdata = c_reg + bit_nb;
            end
            OP_WR_IDX: ram_we = 1'b1;
            OP_PUSH_FREE: begin
                ram_we    = !full;
                ram_waddr = addr_of(b_reg, wrap(head_cur, cnt_cur));
                ram_wdata = c_reg;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // list bookkeeping and free page counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg  <= POOL_ORDER_RST;
            b_reg     <= '0;
            idx_reg   <= '0;
            total_reg <= '0;
            for (int i = 0; i < NORD; i++) begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                pool_reg <= cfg_wr_data;
            end
            unique case (cmd.op)
                OP_INIT: begin
                    for (int i = 0; i < NORD; i++) begin
                        head_reg[i] <= '0;
                        cnt_reg[i]  <= (i == TOP_ORDER) ? n_init : '0;
                    end
                    total_reg <= init_total;
                    idx_reg   <= '0;
                end
                OP_FILL: idx_reg <= idx_reg + CW'(1);
                OP_ACCEPT: begin
                    b_reg   <= B_W'(s_order);
                    idx_reg <= '0;
                end
                OP_SCAN_NEXT: b_reg <= b_reg + B_W'(1);
                OP_POP: begin
                    head_reg[bi] <= wrap(head_cur, CW'(1));
                    cnt_reg[bi]  <= cnt_cur - CW'(1);
                end
                OP_SPLIT: begin
                    b_reg        <= nb;
                    cnt_reg[nbi] <= cnt_nb + CW'(1);
                end
                OP_ALLOC_FIN: total_reg <= sub_sat(total_reg, ord_pages);
                OP_IDX_INC, OP_WR_IDX: idx_reg <= idx_reg + CW'(1);
                OP_MERGE: begin
                    cnt_reg[bi] <= cnt_cur - CW'(1);
                    b_reg       <= b_reg + B_W'(1);
                    idx_reg     <= '0;
                end
                OP_PUSH_FREE: begin
                    if (!full) begin
                        cnt_reg[bi] <= cnt_cur + CW'(1);
                        total_reg   <= add_sat(total_reg, ord_pages);
                    end else begin
                        total_reg   <= sub_sat(total_reg, over_pages);
                    end
                end
                default: ;
            endcase
        end
    end

    // request, working chunk and result registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_ACCEPT: begin
                req_reg <= req_t'(s_req_type);
                ord_reg <= s_order;
                c_reg   <= page_in & ord_mask;
                res_reg <= '0;
                st_reg  <= ST_OK;
            end
            OP_SET_INVALID: st_reg <= ST_INVALID;
            OP_SET_NOMEM:   st_reg <= ST_NO_MEM;
            OP_LATCH:       c_reg  <= ram_rdata;
            OP_ALLOC_FIN:   res_reg <= c_reg;
            OP_MERGE:       c_reg  <= c_reg & ~bit_b;
            OP_PUSH_FREE: begin
                if (full) begin
                    st_reg <= ST_OVERFLOW;
                end
            end
            OP_OUT_LOAD: begin
                m_status_reg <= st_reg;
                m_alloc_reg  <= res32[PAGE_IN_W-1:0];
                m_count_reg  <= total_reg;
            end
            default: ;
        endcase
    end

    bpa_ram #(
        .WIDTH(PAGE_BITS),
        .DEPTH(DEPTH)
    ) u_list_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign m_status          = m_status_reg;
    assign m_alloc_page      = m_alloc_reg;
    assign m_free_page_count = m_count_reg;

endmodule

// ===== src/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator with one FIFO free list of chunk start pages per order.
// ----------------------------------------------------------------------------
// One request is handled at a time; each gives one result beat. After reset
// and after every pool_order write, a fill pass writes the initial top-order
// chunks (up to LIST_DEPTH of them) into the list memory, one per cycle, while
// s_ready stays low. An allocate scans up from the requested order for a
// non-empty list, pops its head and splits it down to the requested order,
// pushing each upper half onto the list one order below. An invalid order
// gives a status beat only. A free walks the list of each order through the
// single read port of the list memory: it compares entries while searching for
// the buddy, moves the later entries down when the buddy is removed, then
// merges, repeated for every merge level, and pushes the chunk at the end.
// The result register frees the input side while a result beat waits on
// m_ready.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int TOP_ORDER  = 11,
    parameter int LIST_DEPTH = 32,
    parameter int PAGE_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [POOL_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [ORD_W-1:0]     s_order,
    input  logic [PAGE_IN_W-1:0] s_page_start,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [PAGE_IN_W-1:0] m_alloc_page,
    output logic [CNT_W-1:0]     m_free_page_count
);

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bpa_dp #(
        .TOP_ORDER (TOP_ORDER),
        .LIST_DEPTH(LIST_DEPTH),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_req_type       (s_req_type),
        .s_order          (s_order),
        .s_page_start     (s_page_start),
        .cmd              (cmd),
        .stat             (stat),
        .m_status         (m_status),
        .m_alloc_page     (m_alloc_page),
        .m_free_page_count(m_free_page_count)
    );

endmodule
